/* src/go_to_goal_turn_then_drive_top_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef GO_TO_GOAL_TURN_THEN_DRIVE_TOP_MACROS_SVH
`define GO_TO_GOAL_TURN_THEN_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GTG_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("go-to-goal check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GTG_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("go-to-goal check failed");

`endif

/* src/gtg_pkg.sv */
package gtg_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int GRID_SIZE_DEF = 16;

	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [REG_IDX_W-1:0] REG_DIST_THR = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEAD_THR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CELL_PITCH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BORDER = 3'd4;

	localparam logic [14:0] DIST_THR_RST = 15'd205;
	localparam logic [14:0] HEAD_THR_RST = 15'd8;
	localparam logic [15:0] GAIN_RST = 16'd6144;
	localparam logic [15:0] CELL_PITCH_RST = 16'd1462;
	localparam logic [15:0] BORDER_RST = 16'd1024;

	localparam int DIFF_W = 18;
	localparam int GUARD = 10;
	localparam int CORDIC_W = 30;
	localparam int ANGLE_W = 20;
	localparam int BRG_W = 17;
	localparam int ERR_W = 18;
	localparam int MUL_W = 18;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W = 33;
	localparam int ROOT_W = 17;
	localparam int ATAN_IDX_W = 5;

	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q16 = ANGLE_W'(102944);
	localparam logic signed [BRG_W-1:0] BEARING_VERT = BRG_W'(12870);

	typedef struct packed {
		logic [14:0] dist_thr;
		logic [14:0] head_thr;
		logic [15:0] gain;
		logic [15:0] cell_pitch;
		logic [15:0] border;
	} cfg_t;

	typedef enum logic [1:0] {
		PH_TURN = 2'd0,
		PH_DRIVE = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_DXX,
		MUL_DYY,
		MUL_ERR,
		MUL_LIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_ANG,
		OUT_LIN
	} out_kind_t;

	typedef struct packed {
		logic latch_in;
		logic diff;
		logic cordic_init;
		logic cordic_step;
		logic err_calc;
		mul_sel_t mul_sel;
		logic acc_load;
		logic sqrt_init;
		logic sqrt_step;
		logic load_out;
		out_kind_t out_kind;
		phase_t out_phase;
	} cmd_t;

	typedef struct packed {
		logic turn_big;
		logic dist_big;
		logic sqrt_last;
	} sts_t;

	// Arctangent of 2^-i in units of 2^-16 rad.
	function automatic logic [15:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [15:0] a;
		case (idx)
			5'd0: a = 16'd51472;
			5'd1: a = 16'd30386;
			5'd2: a = 16'd16055;
			5'd3: a = 16'd8150;
			5'd4: a = 16'd4091;
			5'd5: a = 16'd2047;
			5'd6: a = 16'd1024;
			5'd7: a = 16'd512;
			5'd8: a = 16'd256;
			5'd9: a = 16'd128;
			5'd10: a = 16'd64;
			5'd11: a = 16'd32;
			5'd12: a = 16'd16;
			5'd13: a = 16'd8;
			5'd14: a = 16'd4;
			5'd15: a = 16'd2;
			5'd16: a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

endpackage

/* src/gtg_regs.sv */
module gtg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [gtg_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [gtg_pkg::CFG_DATA_W-1:0]      wr_data,
	output gtg_pkg::cfg_t                       cfg
);

	gtg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dist_thr <= gtg_pkg::DIST_THR_RST;
			cfg_q.head_thr <= gtg_pkg::HEAD_THR_RST;
			cfg_q.gain <= gtg_pkg::GAIN_RST;
			cfg_q.cell_pitch <= gtg_pkg::CELL_PITCH_RST;
			cfg_q.border <= gtg_pkg::BORDER_RST;
		end else if (wr_en) begin
			case (wr_index)
				gtg_pkg::REG_DIST_THR: cfg_q.dist_thr <= wr_data[14:0];
				gtg_pkg::REG_HEAD_THR: cfg_q.head_thr <= wr_data[14:0];
				gtg_pkg::REG_GAIN: cfg_q.gain <= wr_data;
				gtg_pkg::REG_CELL_PITCH: cfg_q.cell_pitch <= wr_data;
				gtg_pkg::REG_BORDER: cfg_q.border <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/gtg_ctrl.sv */
module gtg_ctrl #(
	parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_move,
	output logic                              out_valid,
	input  logic                              out_stall,
	input  gtg_pkg::sts_t                     sts,
	output gtg_pkg::cmd_t                     cmd,
	output logic [$clog2(CORDIC_STEPS)-1:0]   iter
);

	localparam int IterW = $clog2(CORDIC_STEPS);
	localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_CINIT,
		S_CITER,
		S_ERR,
		S_TCHK,
		S_OUTA,
		S_SQX,
		S_SQY,
		S_SINIT,
		S_SQRT,
		S_DCHK,
		S_OUTL,
		S_OUTZ
	} state_t;

	state_t state_q;
	gtg_pkg::phase_t phase_q;
	logic [IterW-1:0] cnt_q;
	logic out_valid_q;
	logic accept_in;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign iter = cnt_q;

	always_comb begin
		cmd = '0;
		cmd.out_phase = phase_q;
		case (state_q)
			S_IDLE: cmd.latch_in = accept_in;
			S_DIFF: cmd.diff = 1'b1;
			S_CINIT: cmd.cordic_init = 1'b1;
			S_CITER: cmd.cordic_step = 1'b1;
			S_ERR: cmd.err_calc = 1'b1;
			S_TCHK: cmd.mul_sel = gtg_pkg::MUL_ERR;
			S_OUTA: begin
				cmd.load_out = out_free;
				cmd.out_kind = gtg_pkg::OUT_ANG;
			end
			S_SQX: cmd.mul_sel = gtg_pkg::MUL_DXX;
			S_SQY: begin
				cmd.mul_sel = gtg_pkg::MUL_DYY;
				cmd.acc_load = 1'b1;
			end
			S_SINIT: cmd.sqrt_init = 1'b1;
			S_SQRT: cmd.sqrt_step = 1'b1;
			S_DCHK: cmd.mul_sel = gtg_pkg::MUL_LIN;
			S_OUTL: begin
				cmd.load_out = out_free;
				cmd.out_kind = gtg_pkg::OUT_LIN;
			end
			S_OUTZ: begin
				cmd.load_out = out_free;
				cmd.out_kind = gtg_pkg::OUT_ZERO;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= gtg_pkg::PH_DONE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (start_move) begin
							phase_q <= gtg_pkg::PH_TURN;
						end
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					case (phase_q)
						gtg_pkg::PH_TURN: state_q <= S_CINIT;
						gtg_pkg::PH_DRIVE: state_q <= S_SQX;
						default: state_q <= S_OUTZ;
					endcase
				end
				S_CINIT: begin
					cnt_q <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					if (cnt_q == IterLast) begin
						state_q <= S_ERR;
					end else begin
						cnt_q <= cnt_q + IterW'(1);
					end
				end
				S_ERR: state_q <= S_TCHK;
				S_TCHK: begin
					if (sts.turn_big) begin
						state_q <= S_OUTA;
					end else begin
						phase_q <= gtg_pkg::PH_DRIVE;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SINIT;
				S_SINIT: state_q <= S_SQRT;
				S_SQRT: begin
					if (sts.sqrt_last) begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					if (sts.dist_big) begin
						state_q <= S_OUTL;
					end else begin
						phase_q <= gtg_pkg::PH_DONE;
						state_q <= S_OUTZ;
					end
				end
				S_OUTA, S_OUTL, S_OUTZ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/gtg_dp.sv */
module gtg_dp #(
	parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF,
	parameter int GRID_SIZE = gtg_pkg::GRID_SIZE_DEF
) (
	input  logic                              clk,
	input  gtg_pkg::cfg_t                     cfg,
	input  gtg_pkg::cmd_t                     cmd,
	input  logic [$clog2(CORDIC_STEPS)-1:0]   iter,
	input  logic                              start_move,
	input  logic [3:0]                        goal_col,
	input  logic [3:0]                        goal_row,
	input  logic signed [15:0]                pose_x,
	input  logic signed [15:0]                pose_y,
	input  logic signed [15:0]                pose_theta,
	output gtg_pkg::sts_t                     sts,
	output logic [14:0]                       linear_speed,
	output logic signed [15:0]                angular_rate,
	output logic [1:0]                        phase_out
);

	localparam int DW = gtg_pkg::DIFF_W;
	localparam int CW = gtg_pkg::CORDIC_W;
	localparam int AW = gtg_pkg::ANGLE_W;
	localparam int BW = gtg_pkg::BRG_W;
	localparam int EW = gtg_pkg::ERR_W;
	localparam int MW = gtg_pkg::MUL_W;
	localparam int PW = gtg_pkg::PROD_W;
	localparam int SW = gtg_pkg::SUM_W;
	localparam int RW = gtg_pkg::ROOT_W;
	localparam int CellMaxI = (GRID_SIZE - 1 > 15) ? 15 : GRID_SIZE - 1;
	localparam logic [3:0] CellMax = 4'(CellMaxI);
	localparam logic signed [AW-1:0] ZRound = AW'(4);
	localparam logic signed [PW-1:0] AngHalf = PW'(1) <<< 13;
	localparam logic signed [PW-1:0] LinHalf = PW'(1) <<< 11;
	localparam logic signed [PW-1:0] AngMax = PW'(32767);
	localparam logic signed [PW-1:0] AngMin = -PW'(32768);
	localparam logic signed [PW-1:0] LinMax = PW'(32767);

	function automatic logic signed [15:0] world_goal(input logic [3:0] grid_idx,
			input logic [15:0] pitch, input logic [15:0] border);
		logic [3:0] c;
		logic [20:0] w;
		c = (grid_idx > CellMax) ? CellMax : grid_idx;
		w = 21'(border) + 21'(c) * 21'(pitch);
		return (w > 21'd32767) ? 16'sd32767 : 16'(w);
	endfunction

	logic signed [15:0] goal_x_q, goal_y_q, px_q, py_q, th_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [AW-1:0] z_q;
	logic signed [EW-1:0] err_q;
	logic signed [PW-1:0] prod_q;
	logic [SW-1:0] acc_q, n_q, bit_q;
	logic [SW:0] res_q;
	logic [14:0] lin_q;
	logic signed [15:0] ang_q;
	logic [1:0] ph_out_q;

	logic signed [CW-1:0] xs, ys, x0, y0, sh_x, sh_y, x1, y1;
	logic signed [AW-1:0] z0, z1, a_s, zr;
	logic signed [BW-1:0] brg_c;
	logic [EW-1:0] mag_c;
	logic signed [MW-1:0] ma, mb;
	logic [SW:0] trial;
	logic signed [PW-1:0] rnd_a, sh_a, rnd_l, sh_l;
	logic signed [15:0] sat_a;
	logic [14:0] sat_l;

	always_comb begin
		xs = CW'(dx_q) <<< gtg_pkg::GUARD;
		ys = CW'(dy_q) <<< gtg_pkg::GUARD;
		if (dx_q < 0) begin
			if (dy_q >= 0) begin
				x0 = ys;
				y0 = -xs;
				z0 = gtg_pkg::HALF_PI_Q16;
			end else begin
				x0 = -ys;
				y0 = xs;
				z0 = -gtg_pkg::HALF_PI_Q16;
			end
		end else begin
			x0 = xs;
			y0 = ys;
			z0 = '0;
		end
	end

	always_comb begin
		sh_x = cx_q >>> iter;
		sh_y = cy_q >>> iter;
		a_s = AW'(gtg_pkg::atan_q16(gtg_pkg::ATAN_IDX_W'(iter)));
		if (cy_q >= 0) begin
			x1 = cx_q + sh_y;
			y1 = cy_q - sh_x;
			z1 = z_q + a_s;
		end else begin
			x1 = cx_q - sh_y;
			y1 = cy_q + sh_x;
			z1 = z_q - a_s;
		end
	end

	always_comb begin
		zr = z_q + ZRound;
		if (dx_q == '0) begin
			brg_c = (py_q > goal_y_q) ? -gtg_pkg::BEARING_VERT : gtg_pkg::BEARING_VERT;
		end else begin
			brg_c = BW'(zr >>> 3);
		end
		mag_c = (err_q < 0) ? -err_q : err_q;
	end

	always_comb begin
		case (cmd.mul_sel)
			gtg_pkg::MUL_DXX: begin
				ma = dx_q;
				mb = dx_q;
			end
			gtg_pkg::MUL_DYY: begin
				ma = dy_q;
				mb = dy_q;
			end
			gtg_pkg::MUL_ERR: begin
				ma = err_q;
				mb = MW'(cfg.gain);
			end
			gtg_pkg::MUL_LIN: begin
				ma = MW'(res_q[RW-1:0]);
				mb = MW'(cfg.gain);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		trial = res_q + (SW + 1)'(bit_q);
		rnd_a = prod_q + AngHalf;
		sh_a = rnd_a >>> 14;
		rnd_l = prod_q + LinHalf;
		sh_l = rnd_l >>> 12;
		if (sh_a > AngMax) begin
			sat_a = 16'sd32767;
		end else if (sh_a < AngMin) begin
			sat_a = -16'sd32768;
		end else begin
			sat_a = 16'(sh_a);
		end
		sat_l = (sh_l > LinMax) ? 15'd32767 : 15'(sh_l);
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			px_q <= pose_x;
			py_q <= pose_y;
			th_q <= pose_theta;
			if (start_move) begin
				goal_x_q <= world_goal(goal_col, cfg.cell_pitch, cfg.border);
				goal_y_q <= world_goal(goal_row, cfg.cell_pitch, cfg.border);
			end
		end
		if (cmd.diff) begin
			dx_q <= DW'(goal_x_q) - DW'(px_q);
			dy_q <= DW'(goal_y_q) - DW'(py_q);
		end
		if (cmd.cordic_init) begin
			cx_q <= x0;
			cy_q <= y0;
			z_q <= z0;
		end else if (cmd.cordic_step) begin
			cx_q <= x1;
			cy_q <= y1;
			z_q <= z1;
		end
		if (cmd.err_calc) begin
			err_q <= EW'(brg_c) - EW'(th_q);
		end
		if (cmd.mul_sel != gtg_pkg::MUL_NONE) begin
			prod_q <= ma * mb;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q[SW-1:0];
		end
		if (cmd.sqrt_init) begin
			n_q <= acc_q + prod_q[SW-1:0];
			res_q <= '0;
			bit_q <= SW'(1) << (SW - 1);
		end else if (cmd.sqrt_step) begin
			if ((SW + 1)'(n_q) >= trial) begin
				n_q <= n_q - trial[SW-1:0];
				res_q <= (res_q >> 1) + (SW + 1)'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.load_out) begin
			case (cmd.out_kind)
				gtg_pkg::OUT_ANG: begin
					ang_q <= sat_a;
					lin_q <= '0;
				end
				gtg_pkg::OUT_LIN: begin
					ang_q <= '0;
					lin_q <= sat_l;
				end
				default: begin
					ang_q <= '0;
					lin_q <= '0;
				end
			endcase
			ph_out_q <= cmd.out_phase;
		end
	end

	assign sts.turn_big = mag_c > EW'(cfg.head_thr);
	assign sts.dist_big = res_q[RW-1:0] > RW'(cfg.dist_thr);
	assign sts.sqrt_last = bit_q[0];

	assign linear_speed = lin_q;
	assign angular_rate = ang_q;
	assign phase_out = ph_out_q;

endmodule

/* src/go_to_goal_turn_then_drive_top.sv */
// Turn-then-drive go-to-goal controller. Each accepted pose item yields exactly one
// command item, handled one at a time. A pose item in the arrived phase with no start
// goes from the difference step straight to the zero command; a turning item runs the
// difference, the vectoring CORDIC, which does one rotation per cycle, the heading error
// and the heading check before its angular command; a driving item runs the two squares,
// the 17 steps of the bit-pair square root and the distance check before its linear or
// zero command; an item whose turn ends goes on to the driving steps. A finished command
// waits in an output register, and the block accepts the next item while it is still held there.
// Configuration writes are taken at any cycle but belong to idle periods.
module go_to_goal_turn_then_drive_top #(
	parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF,
	parameter int GRID_SIZE = gtg_pkg::GRID_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_move,
	input  logic [3:0]                        goal_col,
	input  logic [3:0]                        goal_row,
	input  logic signed [15:0]                pose_x,
	input  logic signed [15:0]                pose_y,
	input  logic signed [15:0]                pose_theta,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [14:0]                       linear_speed,
	output logic signed [15:0]                angular_rate,
	output logic [1:0]                        phase_out,
	input  logic                              cfg_wr_en,
	input  logic [gtg_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [gtg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IterW = $clog2(CORDIC_STEPS);

	gtg_pkg::cfg_t cfg;
	gtg_pkg::cmd_t cmd;
	gtg_pkg::sts_t sts;
	logic [IterW-1:0] iter;

	gtg_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gtg_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.start_move (start_move),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sts        (sts),
		.cmd        (cmd),
		.iter       (iter)
	);

	gtg_dp #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.GRID_SIZE    (GRID_SIZE)
	) u_dp (
		.clk          (clk),
		.cfg          (cfg),
		.cmd          (cmd),
		.iter         (iter),
		.start_move   (start_move),
		.goal_col     (goal_col),
		.goal_row     (goal_row),
		.pose_x       (pose_x),
		.pose_y       (pose_y),
		.pose_theta   (pose_theta),
		.sts          (sts),
		.linear_speed (linear_speed),
		.angular_rate (angular_rate),
		.phase_out    (phase_out)
	);

endmodule

/* src/gtg_checker.sv */
`include "go_to_goal_turn_then_drive_top_macros.svh"

module gtg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [14:0]                       linear_speed,
	input logic signed [15:0]                angular_rate,
	input logic [1:0]                        phase_out
);

	// An accepted item keeps the block busy for at least the following cycle.
	`GTG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	`GTG_ASSERT_IMP(a_turn_no_speed, out_valid && phase_out == gtg_pkg::PH_TURN, linear_speed == 15'd0)

	`GTG_ASSERT_IMP(a_rate_only_turning, out_valid && phase_out != gtg_pkg::PH_TURN, angular_rate == 16'sd0)

	`GTG_ASSERT_IMP(a_arrived_stopped, out_valid && phase_out == gtg_pkg::PH_DONE, linear_speed == 15'd0)

	`GTG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(linear_speed) && $stable(angular_rate) && $stable(phase_out))

endmodule

bind go_to_goal_turn_then_drive_top gtg_checker u_checker (.*);
